FILE: src/tseq_pkg.sv
package tseq_pkg;

  localparam int TIME_W = 32;
  localparam int TYPE_W = 8;
  localparam int CNT_W  = 5;

  // operation codes of a request
  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_POP    = 1'b1
  } func_t;

  // one stored entry as seen by the neighbors
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] event_time;
    logic [TYPE_W-1:0] event_type;
  } entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic              en;
    func_t             func;
    logic [TIME_W-1:0] event_time;
    logic [TYPE_W-1:0] event_type;
  } cell_cmd_t;

endpackage

FILE: src/tseq_cell.sv
module tseq_cell
  import tseq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  logic      left_le,
  input  entry_t    left_ent,
  input  entry_t    right_ent,
  output logic      le,
  output entry_t    ent
);

  logic              valid_r, valid_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TYPE_W-1:0] type_r, type_nxt;

  // held entry is at or before the new time: it stays where it is
  assign le  = valid_r && (time_r <= cmd.event_time);
  assign ent = '{valid: valid_r, event_time: time_r, event_type: type_r};

  // insert: keep, take the new entry, or take the left neighbor's
  // pop: take the right neighbor's entry
  always_comb begin
    valid_nxt = valid_r;
    time_nxt  = time_r;
    type_nxt  = type_r;
    if (cmd.en) begin
      if (cmd.func == FUNC_POP) begin
        valid_nxt = right_ent.valid;
        time_nxt  = right_ent.event_time;
        type_nxt  = right_ent.event_type;
      end else if (!le) begin
        if (left_le) begin
          valid_nxt = 1'b1;
          time_nxt  = cmd.event_time;
          type_nxt  = cmd.event_type;
        end else begin
          valid_nxt = left_ent.valid;
          time_nxt  = left_ent.event_time;
          type_nxt  = left_ent.event_type;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    type_r <= type_nxt;
  end

endmodule

FILE: src/time_sorted_event_queue_unit.sv
// Sorted event queue, earliest time first. Entries live in a row of CAPACITY
// cells kept in ascending time order; cell 0 holds the earliest. Every cell
// compares its own time with the request in parallel, so an insert shifts the
// later entries one cell right and a pop shifts all entries one cell left at
// once. One request is taken per clock while the result register is free or
// being drained; each request gives one result in the cycle after it is taken.
// Equal times leave in arrival order. A pop of an empty queue returns
// pop_valid low with zero time and type; an insert into a full queue is
// dropped with insert_dropped high. entry_count is the count after the
// request, taken modulo 32.
module time_sorted_event_queue_unit
  import tseq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic [TIME_W-1:0] in_event_time,
  input  logic [TYPE_W-1:0] in_event_type,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_pop_valid,
  output logic [TIME_W-1:0] out_popped_time,
  output logic [TYPE_W-1:0] out_popped_type,
  output logic              out_insert_dropped,
  output logic [CNT_W-1:0]  out_entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  entry_t            ent [CAPACITY];
  logic [CAPACITY-1:0] le;
  logic [CAPACITY-1:0] valid_vec;
  cell_cmd_t         cmd;
  logic              accept, empty, full, is_pop;

  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              pop_valid_r, pop_valid_nxt;
  logic [TIME_W-1:0] ptime_r, ptime_nxt;
  logic [TYPE_W-1:0] ptype_r, ptype_nxt;
  logic              dropped_r, dropped_nxt;
  logic [CW+CNT_W-1:0] count_ext;

  // request handshake: the result register frees as it drains
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_pop   = (func_t'(in_func) == FUNC_POP);
  assign empty    = !ent[0].valid;
  assign full     = ent[CAPACITY-1].valid;

  // broadcast; state changes only for a pop with data or an insert with room
  always_comb begin
    cmd.en         = accept && (is_pop ? !empty : !full);
    cmd.func       = func_t'(in_func);
    cmd.event_time = in_event_time;
    cmd.event_type = in_event_type;
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   left_le_w;
    entry_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_le_w = 1'b1;
      assign left_w    = '0;
    end else begin : g_mid
      assign left_le_w = le[i-1];
      assign left_w    = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_notlast
      assign right_w = ent[i+1];
    end
    tseq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_le   (left_le_w),
      .left_ent  (left_w),
      .right_ent (right_w),
      .le        (le[i]),
      .ent       (ent[i])
    );
    assign valid_vec[i] = ent[i].valid;
  end

  // result of the request and the new count
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    pop_valid_nxt = pop_valid_r;
    ptime_nxt     = ptime_r;
    ptype_nxt     = ptype_r;
    dropped_nxt   = dropped_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      pop_valid_nxt = 1'b0;
      ptime_nxt     = '0;
      ptype_nxt     = '0;
      dropped_nxt   = 1'b0;
      if (is_pop) begin
        if (!empty) begin
          pop_valid_nxt = 1'b1;
          ptime_nxt     = ent[0].event_time;
          ptype_nxt     = ent[0].event_type;
          count_nxt     = count_r - CW'(1);
        end
      end else if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_valid_r <= pop_valid_nxt;
    ptime_r     <= ptime_nxt;
    ptype_r     <= ptype_nxt;
    dropped_r   <= dropped_nxt;
  end

  assign count_ext          = {{CNT_W{1'b0}}, count_r};
  assign out_valid          = out_valid_r;
  assign out_pop_valid      = pop_valid_r;
  assign out_popped_time    = ptime_r;
  assign out_popped_type    = ptype_r;
  assign out_insert_dropped = dropped_r;
  assign out_entry_count    = count_ext[CNT_W-1:0];

  // occupied cells always form a prefix of the row
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, valid_vec} + (CAPACITY + 1)'(1)))
    else $error("occupied cells not contiguous");

  // count tracks the occupied cells
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("count out of step with cells");

  // a dropped insert only comes from a full queue
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_pop |=> (dropped_r == $past(full)))
    else $error("drop flag does not match fullness");

  // head of the row is never later than its successor
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    ent[1 % CAPACITY].valid |-> (ent[0].event_time <= ent[1 % CAPACITY].event_time))
    else $error("head entry out of order");

endmodule

FILE: test/time_sorted_event_queue_checker.sv
module time_sorted_event_queue_checker
  import tseq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_func,
  input  logic [TIME_W-1:0] in_event_time,
  input  logic [TYPE_W-1:0] in_event_type,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_pop_valid,
  input  logic [TIME_W-1:0] out_popped_time,
  input  logic [TYPE_W-1:0] out_popped_type,
  input  logic              out_insert_dropped,
  input  logic [CNT_W-1:0]  out_entry_count,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              pop_valid;
    logic [TIME_W-1:0] popped_time;
    logic [TYPE_W-1:0] popped_type;
    logic              insert_dropped;
    logic [CNT_W-1:0]  entry_count;
  } outcome_t;

  // shadow queue, earliest entry in slot 0
  logic [TIME_W-1:0] slot_time [CAPACITY];
  logic [TYPE_W-1:0] slot_type [CAPACITY];
  int unsigned       held;

  outcome_t expected_outcomes[$];
  int       fails = 0;

  // apply one request to the shadow queue and return its result
  function automatic outcome_t apply_queue_op(func_t op, logic [TIME_W-1:0] t,
                                              logic [TYPE_W-1:0] ty);
    outcome_t    r;
    int unsigned pos;
    r = '0;
    if (op == FUNC_INSERT) begin
      if (held >= CAPACITY) begin
        r.insert_dropped = 1'b1;
      end else begin
        // ties go behind entries already held
        pos = 0;
        while (pos < held && slot_time[pos] <= t) pos++;
        for (int unsigned i = held; i > pos; i--) begin
          slot_time[i] = slot_time[i-1];
          slot_type[i] = slot_type[i-1];
        end
        slot_time[pos] = t;
        slot_type[pos] = ty;
        held++;
      end
    end else if (held > 0) begin
      r.pop_valid   = 1'b1;
      r.popped_time = slot_time[0];
      r.popped_type = slot_type[0];
      for (int unsigned i = 1; i < held; i++) begin
        slot_time[i-1] = slot_time[i];
        slot_type[i-1] = slot_type[i];
      end
      held--;
    end
    r.entry_count = held[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t got;
    outcome_t want;
    if (!rst_n) begin
      held = 0;
      expected_outcomes.delete();
    end else begin
      // result side
      if (out_valid && !out_stall) begin
        got = '{out_pop_valid, out_popped_time, out_popped_type,
                out_insert_dropped, out_entry_count};
        if (expected_outcomes.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = expected_outcomes.pop_front();
          if (got.pop_valid !== want.pop_valid) begin
            $error("pop_valid: expected %0h, actual %0h", want.pop_valid, got.pop_valid);
            fails++;
          end
          if (got.popped_time !== want.popped_time) begin
            $error("popped_time: expected %h, actual %h", want.popped_time,
                   got.popped_time);
            fails++;
          end
          if (got.popped_type !== want.popped_type) begin
            $error("popped_type: expected %h, actual %h", want.popped_type,
                   got.popped_type);
            fails++;
          end
          if (got.insert_dropped !== want.insert_dropped) begin
            $error("insert_dropped: expected %0h, actual %0h", want.insert_dropped,
                   got.insert_dropped);
            fails++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   got.entry_count);
            fails++;
          end
        end
      end
      // request side
      if (in_valid && !in_stall) begin
        expected_outcomes.push_back(apply_queue_op(func_t'(in_func), in_event_time,
                                                   in_event_type));
      end
    end
    fail_count <= fails;
    pending    <= expected_outcomes.size();
  end

endmodule

FILE: test/time_sorted_event_queue_unit_tb.sv
module time_sorted_event_queue_unit_tb;
  import tseq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 16;
  localparam int PHASE_ITEMS = 470;

  logic              clk                = 1'b0;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_func            = FUNC_INSERT;
  logic [TIME_W-1:0] in_event_time      = '0;
  logic [TYPE_W-1:0] in_event_type      = '0;
  logic              out_stall          = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              out_pop_valid;
  logic [TIME_W-1:0] out_popped_time;
  logic [TYPE_W-1:0] out_popped_type;
  logic              out_insert_dropped;
  logic [CNT_W-1:0]  out_entry_count;
  int                fail_count;
  int                pending;

  // idle rates in percent
  int in_gap_pct    = 8;
  int out_stall_pct = 50;

  always #4 clk = ~clk;

  time_sorted_event_queue_unit #(.CAPACITY(CAPACITY)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_event_time      (in_event_time),
    .in_event_type      (in_event_type),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pop_valid      (out_pop_valid),
    .out_popped_time    (out_popped_time),
    .out_popped_type    (out_popped_type),
    .out_insert_dropped (out_insert_dropped),
    .out_entry_count    (out_entry_count)
  );

  time_sorted_event_queue_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_event_time      (in_event_time),
    .in_event_type      (in_event_type),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pop_valid      (out_pop_valid),
    .out_popped_time    (out_popped_time),
    .out_popped_type    (out_popped_type),
    .out_insert_dropped (out_insert_dropped),
    .out_entry_count    (out_entry_count),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // result-side backpressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // present one request and hold it until taken
  task automatic send_request(func_t op, logic [TIME_W-1:0] t, logic [TYPE_W-1:0] ty);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= op;
    in_event_time <= t;
    in_event_type <= ty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // bursts that lean toward filling, draining or churning the queue
  task automatic send_random_bursts(int count);
    int                left;
    int                burst;
    int                lean;
    int                pick;
    func_t             op;
    logic [TIME_W-1:0] t;
    left = count;
    while (left > 0) begin
      lean  = $urandom_range(0, 2);
      burst = $urandom_range(4, 40);
      for (int i = 0; i < burst && left > 0; i++) begin
        case (lean)
          0: op = ($urandom_range(0, 99) < 85) ? FUNC_INSERT : FUNC_POP;
          1: op = ($urandom_range(0, 99) < 85) ? FUNC_POP : FUNC_INSERT;
          default: op = ($urandom_range(0, 1) != 0) ? FUNC_POP : FUNC_INSERT;
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
          0, 1, 2, 3: t = $urandom;
          4, 5, 6:    t = $urandom_range(0, 7);            // many ties
          7:          t = '0;
          8:          t = '1;
          default:    t = 32'h0001_0000 + $urandom_range(0, 3);
        endcase
        send_request(op, t, TYPE_W'($urandom_range(0, 255)));
        left--;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, extremes, ties in arrival order, drain past empty
    send_request(FUNC_POP,    32'h0000_0000, 8'h00);
    send_request(FUNC_INSERT, 32'hFFFF_FFFF, 8'hFF);
    send_request(FUNC_INSERT, 32'h0000_0000, 8'h00);
    send_request(FUNC_INSERT, 32'h0001_0000, 8'h01);
    send_request(FUNC_INSERT, 32'h0001_0000, 8'h02);
    send_request(FUNC_INSERT, 32'h0001_0000, 8'h03);
    send_request(FUNC_INSERT, 32'h0000_FFFF, 8'h80);
    send_request(FUNC_INSERT, 32'hFFFF_FFFF, 8'h7F);
    repeat (8) send_request(FUNC_POP, 32'hFFFF_FFFF, 8'hFF);

    send_random_bursts(PHASE_ITEMS);

    in_gap_pct    = 50;
    out_stall_pct = 8;
    send_random_bursts(PHASE_ITEMS);

    in_gap_pct    = 0;
    out_stall_pct = 0;
    send_random_bursts(PHASE_ITEMS);

    // drain outstanding results, then settle
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: time_sorted_event_queue_unit.f
src/tseq_pkg.sv
src/tseq_cell.sv
src/time_sorted_event_queue_unit.sv
test/time_sorted_event_queue_checker.sv
test/time_sorted_event_queue_unit_tb.sv
